// ===== sv/ffsa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ffsa_pkg
// Types and codes shared by the first-fit slot allocator and its cells.
// ----------------------------------------------------------------------------
package ffsa_pkg;

    localparam int FFSA_SLOTS = 16;

    localparam logic [1:0] KIND_ALLOC   = 2'd0;
    localparam logic [1:0] KIND_DEALLOC = 2'd1;
    localparam logic [1:0] KIND_COMPACT = 2'd2;
    localparam logic [1:0] KIND_READ    = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOSPACE  = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_BAD      = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic [4:0] req_size;
        logic [7:0] owner_id;
        logic [3:0] slot_index;
    } ffsa_req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] start_slot;
        logic [7:0] slot_owner;
    } ffsa_rsp_t;

    typedef struct packed {
        logic shift_en;
        logic swap_en;
        logic phase;
    } ffsa_cell_ctrl_t;

endpackage
`default_nettype wire

// ===== sv/ffsa_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ffsa_cell
// One slot of the ring: holds an owner id, shifts toward the head, or takes
// part in an odd-even exchange that moves owned slots toward the front.
// ----------------------------------------------------------------------------
module ffsa_cell (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire ffsa_pkg::ffsa_cell_ctrl_t ctrl,
    input  wire logic                      odd,
    input  wire logic                      has_left,
    input  wire logic                      has_right,
    input  wire logic [7:0]                left_val,
    input  wire logic [7:0]                right_val,
    output logic      [7:0]                value
);
    import ffsa_pkg::*;

    logic [7:0] value_reg;
    logic [7:0] value_next;
    logic       pair_right;

    assign pair_right = (odd == ctrl.phase);
    assign value      = value_reg;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.shift_en)
        begin
            value_next = right_val;
        end
        else if (ctrl.swap_en)
        begin
            if (pair_right)
            begin
                if (has_right && (value_reg == 8'd0) && (right_val != 8'd0))
                begin
                    value_next = right_val;
                end
            end
            else
            begin
                if (has_left && (left_val == 8'd0) && (value_reg != 8'd0))
                begin
                    value_next = left_val;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= 8'd0;
        end
        else
        begin
            value_reg <= value_next;
        end
    end

endmodule
`default_nettype wire

// ===== sv/ffsa_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ffsa_ctrl
// Request sequencer: watches the head of the ring, feeds its tail, counts
// passes and holds the response word.
// ----------------------------------------------------------------------------
module ffsa_ctrl #(
    parameter int SLOTS = ffsa_pkg::FFSA_SLOTS
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      req_valid,
    output logic                           req_stall,
    input  wire ffsa_pkg::ffsa_req_t       req,
    output logic                           rsp_valid,
    input  wire logic                      rsp_stall,
    output ffsa_pkg::ffsa_rsp_t            rsp,
    input  wire logic [7:0]                head,
    output logic      [7:0]                feed,
    output ffsa_pkg::ffsa_cell_ctrl_t      cell_ctrl
);
    import ffsa_pkg::*;

    localparam int IW = $clog2(SLOTS);
    localparam int RW = $clog2(SLOTS + 1);
    localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);
    localparam logic [8:0] SLOTS_W = 9'(SLOTS);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SCAN    = 3'd1;
    localparam logic [2:0] S_WRITE   = 3'd2;
    localparam logic [2:0] S_DEALLOC = 3'd3;
    localparam logic [2:0] S_COMPACT = 3'd4;
    localparam logic [2:0] S_READ    = 3'd5;
    localparam logic [2:0] S_DONE    = 3'd6;

    logic [2:0]    state_reg, state_next;
    logic [IW-1:0] cnt_reg, cnt_next;
    logic          rsp_valid_reg, rsp_valid_next;
    ffsa_req_t     req_reg, req_next;
    logic [RW-1:0] run_reg, run_next;
    logic [IW-1:0] start_reg, start_next;
    logic [8:0]    end_reg, end_next;
    logic          found_reg, found_next;
    logic          hit_reg, hit_next;
    logic [1:0]    status_reg, status_next;
    logic [7:0]    owner_reg, owner_next;
    ffsa_rsp_t     rsp_reg, rsp_next;
    logic          last;
    logic          in_run;
    logic [IW-1:0] run_start;

    assign last      = (cnt_reg == LAST);
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign run_start = (run_reg == RW'(0)) ? cnt_reg : start_reg;
    assign in_run    = (9'(cnt_reg) >= 9'(start_reg)) && (9'(cnt_reg) < end_reg);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        rsp_valid_next = rsp_valid_reg;
        req_next       = req_reg;
        run_next       = run_reg;
        start_next     = start_reg;
        end_next       = end_reg;
        found_next     = found_reg;
        hit_next       = hit_reg;
        status_next    = status_reg;
        owner_next     = owner_reg;
        rsp_next       = rsp_reg;
        feed           = head;
        cell_ctrl      = '0;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next    = req;
                    cnt_next    = '0;
                    run_next    = '0;
                    start_next  = '0;
                    found_next  = 1'b0;
                    hit_next    = 1'b0;
                    status_next = ST_OK;
                    owner_next  = 8'd0;
                    unique case (req.kind)
                        KIND_ALLOC:
                        begin
                            if ((req.req_size == 5'd0) || (req.owner_id == 8'd0))
                            begin
                                status_next = ST_BAD;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        KIND_DEALLOC:
                        begin
                            if (req.owner_id == 8'd0)
                            begin
                                status_next = ST_BAD;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                state_next = S_DEALLOC;
                            end
                        end
                        KIND_COMPACT:
                        begin
                            state_next = S_COMPACT;
                        end
                        KIND_READ:
                        begin
                            if ({5'd0, req.slot_index} >= SLOTS_W)
                            begin
                                status_next = ST_BAD;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                cell_ctrl.shift_en = 1'b1;
                cnt_next           = cnt_reg + IW'(1);
                if (!found_reg)
                begin
                    if (head == 8'd0)
                    begin
                        start_next = run_start;
                        run_next   = run_reg + RW'(1);
                        if ((9'(run_reg) + 9'd1) == {4'd0, req_reg.req_size})
                        begin
                            found_next = 1'b1;
                            end_next   = 9'(run_start) + {4'd0, req_reg.req_size};
                        end
                    end
                    else
                    begin
                        run_next = '0;
                    end
                end
                if (last)
                begin
                    cnt_next = '0;
                    if (found_next)
                    begin
                        state_next = S_WRITE;
                    end
                    else
                    begin
                        status_next = ST_NOSPACE;
                        state_next  = S_DONE;
                    end
                end
            end
            S_WRITE:
            begin
                cell_ctrl.shift_en = 1'b1;
                cnt_next           = cnt_reg + IW'(1);
                if (in_run)
                begin
                    feed = req_reg.owner_id;
                end
                if (last)
                begin
                    status_next = ST_OK;
                    state_next  = S_DONE;
                end
            end
            S_DEALLOC:
            begin
                cell_ctrl.shift_en = 1'b1;
                cnt_next           = cnt_reg + IW'(1);
                if (head == req_reg.owner_id)
                begin
                    feed     = 8'd0;
                    hit_next = 1'b1;
                end
                if (last)
                begin
                    status_next = hit_next ? ST_OK : ST_NOTFOUND;
                    state_next  = S_DONE;
                end
            end
            S_COMPACT:
            begin
                cell_ctrl.swap_en = 1'b1;
                cell_ctrl.phase   = cnt_reg[0];
                cnt_next          = cnt_reg + IW'(1);
                if (last)
                begin
                    state_next = S_DONE;
                end
            end
            S_READ:
            begin
                cell_ctrl.shift_en = 1'b1;
                cnt_next           = cnt_reg + IW'(1);
                if (9'(cnt_reg) == 9'(req_reg.slot_index))
                begin
                    owner_next = head;
                end
                if (last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next.status     = status_reg;
                    rsp_next.start_slot = 4'd0;
                    rsp_next.slot_owner = owner_reg;
                    if ((req_reg.kind == KIND_ALLOC) && (status_reg == ST_OK))
                    begin
                        rsp_next.start_slot = 4'(start_reg);
                    end
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        run_reg    <= run_next;
        start_reg  <= start_next;
        end_reg    <= end_next;
        found_reg  <= found_next;
        hit_reg    <= hit_next;
        status_reg <= status_next;
        owner_reg  <= owner_next;
        rsp_reg    <= rsp_next;
    end

endmodule
`default_nettype wire

// ===== sv/first_fit_slot_allocator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_slot_allocator
// First-fit allocator of contiguous slots with compaction, built as a ring
// of owner-id cells that rotates past a single sequencer.
// ----------------------------------------------------------------------------
//   channel | valid     | stall     | word
//   request | req_valid | req_stall | req (kind, req_size, owner_id, slot_index)
//   result  | rsp_valid | rsp_stall | rsp (status, start_slot, slot_owner)
//
// Deallocate, compact and read hold the ring for one pass (one rotation step
// or one odd-even exchange round per cycle); allocate holds it for a scan pass
// and, if a free run is found, a write pass. The result is registered in S_DONE
// after the last pass; a rejected request goes from S_IDLE straight to S_DONE.
// Reset clears every slot to free. A stalled result holds the next result in
// its last cycle, and the request side with it.
// ----------------------------------------------------------------------------
module first_fit_slot_allocator #(
    parameter int SLOTS = ffsa_pkg::FFSA_SLOTS
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_stall,
    input  wire ffsa_pkg::ffsa_req_t req,
    output logic                     rsp_valid,
    input  wire logic                rsp_stall,
    output ffsa_pkg::ffsa_rsp_t      rsp
);
    import ffsa_pkg::*;

    logic [7:0]      val [SLOTS];
    logic [7:0]      feed;
    ffsa_cell_ctrl_t cell_ctrl;

    ffsa_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .head      (val[0]),
        .feed      (feed),
        .cell_ctrl (cell_ctrl)
    );

    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        logic [7:0] left_in;
        logic [7:0] right_in;

        if (i == 0)
        begin : g_first
            assign left_in = 8'd0;
        end
        else
        begin : g_mid_l
            assign left_in = val[i-1];
        end

        if (i == SLOTS - 1)
        begin : g_last
            assign right_in = feed;
        end
        else
        begin : g_mid_r
            assign right_in = val[i+1];
        end

        ffsa_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (cell_ctrl),
            .odd       (1'(i % 2)),
            .has_left  (1'(i > 0)),
            .has_right (1'(i < SLOTS - 1)),
            .left_val  (left_in),
            .right_val (right_in),
            .value     (val[i])
        );
    end

endmodule
`default_nettype wire
